// ===== rtl/core/ffba_pkg.sv =====
// ffba_pkg: shared constants and types of the first-fit block allocator
// no dependencies; imported by the allocator top level
package ffba_pkg;

	localparam int ALIGN_BYTES = 4;
	localparam int HDR_BYTES   = 4;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_ALLOC,
		ST_FREE,
		ST_SPLIT,
		ST_RESP
	} ffba_state_t;

endpackage

// ===== rtl/core/ffba_req_if.sv =====
// ffba_req_if: request channel of the allocator (valid/ready plus payload)
// no dependencies
interface ffba_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] alloc_size;
	logic [7:0] free_offset;

	modport source(output valid, req_type, alloc_size, free_offset, input ready);
	modport sink(input valid, req_type, alloc_size, free_offset, output ready);
endinterface

// ===== rtl/core/ffba_rsp_if.sv =====
// ffba_rsp_if: response channel of the allocator (valid/ready plus payload)
// no dependencies
interface ffba_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] alloc_offset;
	logic       alloc_ok;

	modport source(output valid, alloc_offset, alloc_ok, input ready);
	modport sink(input valid, alloc_offset, alloc_ok, output ready);
endinterface

// ===== rtl/core/ffba_ram.sv =====
// ffba_ram: generic single-write, single-read ram with registered read data
// no dependencies
module ffba_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/first_fit_block_allocator.sv =====
// first_fit_block_allocator: first-fit allocator with split and coalescing
// walk: a request visits one block header per cycle in the header ram, up to
//   BUF_BYTES/4 - 1 headers; an allocate that splits a block then writes the
//   header of the remainder before the response is loaded
// throughput: one request at a time; the next is taken once the result is registered
// reset: one ram write after reset puts the single free block in word 0
// depends on ffba_pkg, ffba_req_if, ffba_rsp_if, ffba_ram
module first_fit_block_allocator #(
	parameter int BUF_BYTES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	ffba_req_if.sink   req,
	ffba_rsp_if.source rsp
);
	import ffba_pkg::*;

	localparam int SW    = $clog2(BUF_BYTES);      // header size field
	localparam int HW    = SW + 1;                 // header word: {used, size}
	localparam int PW    = SW + 1;                 // byte position, holds BUF_BYTES
	localparam int SLOTS = BUF_BYTES / 4;
	localparam int AW    = $clog2(SLOTS);
	localparam int NW    = (PW > 9) ? PW : 9;      // wide arithmetic

	ffba_state_t state_q, state_d;

	logic [NW-1:0] need_q, need_d;
	logic [PW-1:0] cur_q, cur_d;
	logic [PW-1:0] prev_q, prev_d;
	logic [PW-1:0] tgt_q, tgt_d;
	logic [SW-1:0] prev_size_q, prev_size_d;
	logic          prev_used_q, prev_used_d;
	logic [AW-1:0] rest_slot_q, rest_slot_d;
	logic [SW-1:0] rest_size_q, rest_size_d;
	logic [7:0]    res_off_q, res_off_d;
	logic          res_ok_q, res_ok_d;

	logic          out_valid_q;
	logic [7:0]    out_off_q;
	logic          out_ok_q;
	logic          load_out;

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [HW-1:0] mem_wdata, mem_rdata;

	logic [SW-1:0] h_size;
	logic          h_used;
	logic [PW-1:0] nxt;
	logic [SW-1:0] msize;
	logic [NW-1:0] spare_w;
	logic [NW-1:0] rest_pos;
	logic [NW-1:0] off_w;
	logic [8:0]    rnd;

	assign h_size = mem_rdata[SW-1:0];
	assign h_used = mem_rdata[SW];

	// walk continues while a header plus one aligned word still fit
	function automatic logic walk_on(input logic [PW-1:0] p);
		walk_on = (NW'(p) + NW'(HDR_BYTES + ALIGN_BYTES)) <= NW'(BUF_BYTES);
	endfunction

	ffba_ram #(
		.WIDTH(HW),
		.DEPTH(SLOTS)
	) u_hdr_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// reads always go ahead of the write address on the chain, so no forwarding
	always_comb begin
		state_d     = state_q;
		need_d      = need_q;
		cur_d       = cur_q;
		prev_d      = prev_q;
		tgt_d       = tgt_q;
		prev_size_d = prev_size_q;
		prev_used_d = prev_used_q;
		rest_slot_d = rest_slot_q;
		rest_size_d = rest_size_q;
		res_off_d   = res_off_q;
		res_ok_d    = res_ok_q;
		mem_we      = 1'b0;
		mem_waddr   = cur_q[SW-1:2];
		mem_wdata   = '0;
		mem_re      = 1'b0;
		mem_raddr   = '0;
		req.ready   = 1'b0;
		load_out    = 1'b0;
		nxt         = '0;
		msize       = '0;
		spare_w     = '0;
		rest_pos    = '0;
		off_w       = NW'(req.free_offset);
		rnd         = ({1'b0, req.alloc_size} + 9'(ALIGN_BYTES - 1)) & ~9'(ALIGN_BYTES - 1);

		case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
				mem_wdata = {1'b0, SW'(BUF_BYTES - HDR_BYTES)};
				state_d   = ST_IDLE;
			end

			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					res_off_d = '0;
					res_ok_d  = 1'b0;
					cur_d     = '0;
					prev_d    = '0;
					need_d    = NW'(rnd);
					if (req.req_type == REQ_ALLOC) begin
						mem_re  = 1'b1;
						state_d = ST_ALLOC;
					end else if (off_w < NW'(HDR_BYTES) ||
							off_w > NW'(BUF_BYTES - ALIGN_BYTES)) begin
						state_d = ST_RESP;
					end else begin
						tgt_d   = PW'(off_w - NW'(HDR_BYTES));
						mem_re  = 1'b1;
						state_d = ST_FREE;
					end
				end
			end

			ST_ALLOC: begin
				if (!h_used && NW'(h_size) >= need_q) begin
					spare_w   = NW'(h_size) - need_q;
					rest_pos  = NW'(cur_q) + need_q + NW'(HDR_BYTES);
					mem_we    = 1'b1;
					res_off_d = 8'(NW'(cur_q) + NW'(HDR_BYTES));
					res_ok_d  = 1'b1;
					if (spare_w >= NW'(ALIGN_BYTES)) begin
						mem_wdata   = {1'b1, need_q[SW-1:0]};
						rest_slot_d = rest_pos[SW-1:2];
						rest_size_d = SW'(spare_w - NW'(HDR_BYTES));
						state_d     = ST_SPLIT;
					end else begin
						mem_wdata = {1'b1, h_size};
						state_d   = ST_RESP;
					end
				end else begin
					nxt = PW'(cur_q + PW'(h_size) + PW'(HDR_BYTES));
					if (walk_on(nxt)) begin
						cur_d     = nxt;
						mem_re    = 1'b1;
						mem_raddr = nxt[SW-1:2];
					end else begin
						state_d = ST_RESP;
					end
				end
			end

			ST_FREE: begin
				if (cur_q == tgt_q) begin
					if (prev_q != cur_q && !prev_used_q) begin
						// merge into the free predecessor, which becomes the target
						msize       = SW'(prev_size_q + h_size + SW'(HDR_BYTES));
						mem_we      = 1'b1;
						mem_waddr   = prev_q[SW-1:2];
						mem_wdata   = {1'b0, msize};
						tgt_d       = prev_q;
						prev_size_d = msize;
						prev_used_d = 1'b0;
						nxt         = PW'(prev_q + PW'(msize) + PW'(HDR_BYTES));
					end else begin
						mem_we      = 1'b1;
						mem_wdata   = {1'b0, h_size};
						prev_d      = cur_q;
						prev_size_d = h_size;
						prev_used_d = 1'b0;
						nxt         = PW'(cur_q + PW'(h_size) + PW'(HDR_BYTES));
					end
					if (walk_on(nxt)) begin
						cur_d     = nxt;
						mem_re    = 1'b1;
						mem_raddr = nxt[SW-1:2];
					end else begin
						state_d = ST_RESP;
					end
				end else if (prev_q == tgt_q) begin
					// successor of the freed block
					if (!h_used) begin
						mem_we    = 1'b1;
						mem_waddr = prev_q[SW-1:2];
						mem_wdata = {prev_used_q,
							SW'(prev_size_q + h_size + SW'(HDR_BYTES))};
					end
					state_d = ST_RESP;
				end else begin
					prev_d      = cur_q;
					prev_size_d = h_size;
					prev_used_d = h_used;
					nxt         = PW'(cur_q + PW'(h_size) + PW'(HDR_BYTES));
					if (walk_on(nxt)) begin
						cur_d     = nxt;
						mem_re    = 1'b1;
						mem_raddr = nxt[SW-1:2];
					end else begin
						state_d = ST_RESP;
					end
				end
			end

			ST_SPLIT: begin
				mem_we    = 1'b1;
				mem_waddr = rest_slot_q;
				mem_wdata = {1'b0, rest_size_q};
				state_d   = ST_RESP;
			end

			ST_RESP: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		need_q      <= need_d;
		cur_q       <= cur_d;
		prev_q      <= prev_d;
		tgt_q       <= tgt_d;
		prev_size_q <= prev_size_d;
		prev_used_q <= prev_used_d;
		rest_slot_q <= rest_slot_d;
		rest_size_q <= rest_size_d;
		res_off_q   <= res_off_d;
		res_ok_q    <= res_ok_d;
		if (load_out) begin
			out_off_q <= res_off_q;
			out_ok_q  <= res_ok_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.alloc_offset = out_off_q;
	assign rsp.alloc_ok     = out_ok_q;

	a_fail_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.alloc_ok |-> rsp.alloc_offset == 8'd0)
		else $error("failed allocate carries a nonzero offset");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && mem_re |-> mem_waddr != mem_raddr)
		else $error("header ram read and write hit the same word");

	a_free_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FREE |-> !res_ok_q)
		else $error("free request holds a grant");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q != ST_IDLE)
		else $error("accepted request did not start a walk");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking bench for first_fit_block_allocator, with its own first-fit heap model
// depends on ffba_pkg, ffba_req_if, ffba_rsp_if and the allocator rtl
module tb_top;
	import ffba_pkg::*;

	localparam int unsigned HEAP_BYTES = 256;
	localparam int unsigned HEAP_WORDS = HEAP_BYTES / 4;
	localparam int unsigned LONG_HOLD  = 300;

	typedef struct packed {
		logic       kind;
		logic [7:0] size;
		logic [7:0] offset;
	} alloc_req_t;

	typedef struct packed {
		logic [7:0] offset;
		logic       ok;
	} grant_t;

	logic clk;
	logic arst_n;

	ffba_req_if req_ch();
	ffba_rsp_if rsp_ch();

	first_fit_block_allocator #(
		.BUF_BYTES(HEAP_BYTES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// heap model: one header per 4-byte word
	int unsigned blk_size [HEAP_WORDS];
	bit          blk_used [HEAP_WORDS];

	alloc_req_t  pending_q[$];
	grant_t      grant_q[$];
	logic [7:0]  live_offs[$];

	int          err_cnt;
	bit          gaps_on;
	bit          req_took;
	bit          rsp_took;
	int unsigned send_gap;
	int unsigned sink_gap;
	int unsigned hold_left;
	int unsigned hold_trig;
	int unsigned hold_seen;

	task automatic flag_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $time, what);
		err_cnt++;
	endtask

	function automatic int unsigned draw_gap();
		return gaps_on ? $urandom_range(8, 0) : 0;
	endfunction

	function automatic void heap_reset();
		for (int i = 0; i < HEAP_WORDS; i++) begin
			blk_size[i] = 0;
			blk_used[i] = 0;
		end
		blk_size[0] = HEAP_BYTES - HDR_BYTES;
	endfunction

	function automatic int unsigned heap_alloc(input int unsigned want_bytes);
		int unsigned need;
		int unsigned pos;
		int unsigned idx;
		int unsigned rest;
		need = (want_bytes + ALIGN_BYTES - 1) & ~(ALIGN_BYTES - 1);
		pos = 0;
		do begin
			idx = (pos >> 2) % HEAP_WORDS;
			if (!blk_used[idx] && blk_size[idx] >= need) begin
				if (blk_size[idx] - need >= ALIGN_BYTES) begin
					rest = ((pos + need + HDR_BYTES) >> 2) % HEAP_WORDS;
					blk_size[rest] = blk_size[idx] - need - HDR_BYTES;
					blk_used[rest] = 0;
					blk_size[idx] = need;
				end
				blk_used[idx] = 1;
				return pos + HDR_BYTES;
			end
			pos += blk_size[idx] + HDR_BYTES;
		end while (pos + HDR_BYTES + ALIGN_BYTES <= HEAP_BYTES);
		return 0;
	endfunction

	function automatic void heap_free(input int unsigned off);
		int unsigned target;
		int unsigned cur;
		int unsigned prev;
		int unsigned ci;
		int unsigned pi;
		if (off < HDR_BYTES || off > HEAP_BYTES - ALIGN_BYTES)
			return;
		target = off - HDR_BYTES;
		cur = 0;
		prev = 0;
		do begin
			ci = (cur >> 2) % HEAP_WORDS;
			pi = (prev >> 2) % HEAP_WORDS;
			if (cur == target) begin
				blk_used[ci] = 0;
				// fold into a free predecessor and keep walking from it
				if (prev != cur && !blk_used[pi]) begin
					blk_size[pi] += blk_size[ci] + HDR_BYTES;
					target = prev;
					cur = prev;
				end
			end else if (prev == target) begin
				if (!blk_used[ci])
					blk_size[pi] += blk_size[ci] + HDR_BYTES;
				break;
			end
			prev = cur;
			cur += blk_size[(cur >> 2) % HEAP_WORDS] + HDR_BYTES;
		end while (cur + HDR_BYTES + ALIGN_BYTES <= HEAP_BYTES);
	endfunction

	function automatic grant_t predict_grant(input alloc_req_t r);
		grant_t g;
		int unsigned granted;
		granted = 0;
		if (r.kind == REQ_ALLOC)
			granted = heap_alloc(r.size);
		else
			heap_free(r.offset);
		g.offset = granted[7:0];
		g.ok = (granted != 0);
		return g;
	endfunction

	function automatic alloc_req_t make_alloc(input int unsigned bytes);
		alloc_req_t r;
		r.kind = REQ_ALLOC;
		r.size = bytes[7:0];
		r.offset = 8'($urandom_range(255, 0));
		return r;
	endfunction

	function automatic alloc_req_t make_free(input int unsigned off);
		alloc_req_t r;
		r.kind = REQ_FREE;
		r.size = 8'($urandom_range(255, 0));
		r.offset = off[7:0];
		return r;
	endfunction

	function automatic alloc_req_t make_random_req();
		int unsigned pick;
		int unsigned sz;
		pick = $urandom_range(99, 0);
		if (pick < 46 && live_offs.size() > 0)
			return make_free(live_offs[$urandom_range(live_offs.size() - 1, 0)]);
		if (pick < 88) begin
			sz = $urandom_range(99, 0);
			if (sz < 70)
				return make_alloc($urandom_range(24, 0));
			else if (sz < 92)
				return make_alloc($urandom_range(96, 25));
			return make_alloc($urandom_range(255, 97));
		end
		// noise: stray offsets and arbitrary sizes
		if (pick < 95)
			return make_free($urandom_range(255, 0));
		return make_alloc($urandom_range(255, 0));
	endfunction

	task automatic feed_random(input int n);
		for (int i = 0; i < n; i++) begin
			while (pending_q.size() >= 2)
				@(negedge clk);
			pending_q.push_back(make_random_req());
		end
	endtask

	task automatic drain();
		@(negedge clk);
		while (pending_q.size() != 0 || req_ch.valid || grant_q.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("Simulation FAILED");
		$finish;
	end

	// request driver
	always @(negedge clk) begin : drv
		alloc_req_t r;
		if (arst_n) begin
			if (!(req_ch.valid && !req_took)) begin
				if (req_took)
					send_gap = draw_gap();
				if (send_gap > 0) begin
					send_gap--;
					req_ch.valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					r = pending_q.pop_front();
					req_ch.req_type    <= r.kind;
					req_ch.alloc_size  <= r.size;
					req_ch.free_offset <= r.offset;
					req_ch.valid       <= 1'b1;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// response ready, with random gaps and a long hold-off when hold_trig changes
	always @(negedge clk) begin
		if (hold_seen != hold_trig) begin
			hold_seen = hold_trig;
			hold_left = LONG_HOLD;
		end
		if (rsp_took)
			sink_gap = draw_gap();
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// accepted requests feed the heap model, accepted responses are checked
	always @(posedge clk) begin : mon
		alloc_req_t r;
		grant_t want;
		int hit;
		req_took = arst_n && req_ch.valid && req_ch.ready;
		rsp_took = arst_n && rsp_ch.valid && rsp_ch.ready;
		if (req_took) begin
			r.kind = req_ch.req_type;
			r.size = req_ch.alloc_size;
			r.offset = req_ch.free_offset;
			want = predict_grant(r);
			grant_q.push_back(want);
			if (r.kind == REQ_ALLOC && want.ok) begin
				live_offs.push_back(want.offset);
			end else if (r.kind == REQ_FREE) begin
				hit = -1;
				for (int i = 0; i < live_offs.size(); i++)
					if (hit < 0 && live_offs[i] == r.offset)
						hit = i;
				if (hit >= 0)
					live_offs.delete(hit);
			end
		end
		if (rsp_took) begin
			if (grant_q.size() == 0) begin
				flag_mismatch($sformatf("response with nothing pending: offset %0d ok %0b",
					rsp_ch.alloc_offset, rsp_ch.alloc_ok));
			end else begin
				want = grant_q.pop_front();
				if (rsp_ch.alloc_offset !== want.offset)
					flag_mismatch($sformatf("alloc_offset %0d, expected %0d",
						rsp_ch.alloc_offset, want.offset));
				if (rsp_ch.alloc_ok !== want.ok)
					flag_mismatch($sformatf("alloc_ok %0b, expected %0b",
						rsp_ch.alloc_ok, want.ok));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_ALLOC;
		req_ch.alloc_size = 8'd0;
		req_ch.free_offset = 8'd0;
		rsp_ch.ready = 1'b0;
		err_cnt = 0;
		gaps_on = 1'b1;
		req_took = 1'b0;
		rsp_took = 1'b0;
		send_gap = 0;
		sink_gap = 0;
		hold_left = 0;
		hold_trig = 0;
		hold_seen = 0;
		heap_reset();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero size, rounding, oversize
		pending_q.push_back(make_alloc(0));
		pending_q.push_back(make_alloc(1));
		pending_q.push_back(make_alloc(3));
		pending_q.push_back(make_alloc(4));
		pending_q.push_back(make_alloc(255));
		pending_q.push_back(make_alloc(253));
		// out of range and unaligned frees
		pending_q.push_back(make_free(0));
		pending_q.push_back(make_free(3));
		pending_q.push_back(make_free(253));
		pending_q.push_back(make_free(255));
		pending_q.push_back(make_free(6));
		pending_q.push_back(make_free(252));
		// double free, then coalesce everything back
		pending_q.push_back(make_free(8));
		pending_q.push_back(make_free(8));
		pending_q.push_back(make_free(4));
		pending_q.push_back(make_free(24));
		pending_q.push_back(make_free(16));
		pending_q.push_back(make_alloc(252));
		pending_q.push_back(make_free(4));
		// leaves a size-0 block in the last word, which the walk never reaches
		pending_q.push_back(make_alloc(248));
		pending_q.push_back(make_alloc(0));
		pending_q.push_back(make_free(4));
		pending_q.push_back(make_alloc(249));
		pending_q.push_back(make_free(4));
		drain();

		gaps_on = 1'b0;
		feed_random(80);
		drain();

		gaps_on = 1'b1;
		feed_random(150);
		hold_trig++;
		feed_random(200);
		drain();

		repeat (80) @(posedge clk);
		if (err_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
